@@ hdl/dclp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dclp_pkg
// Shared types and constants for the FIG 0/5 component language parser.
// ----------------------------------------------------------------------------
package dclp_pkg;

  localparam int SEEN_DEPTH = 64;
  localparam int SEEN_IDX_W = $clog2(SEEN_DEPTH);
  localparam int SEEN_CNT_W = $clog2(SEEN_DEPTH + 1);
  localparam int KEY_W      = 13;

  localparam logic [7:0] ID_MASK   = 8'h3F;
  localparam logic [2:0] RFA_MASK  = 3'h7;
  localparam logic [3:0] SCID_MASK = 4'hF;
  localparam logic       FLAG_MASK = 1'b1;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  typedef struct packed {
    logic        entry_valid;
    logic        long_form;
    logic        fic_flag;
    logic [5:0]  short_id;
    logic [11:0] component_id;
    logic [7:0]  language_code;
    logic        rfa_invalid;
    logic        fig_done;
    logic        fig_complete;
    logic        seen_overflow;
  } entry_t;

  typedef struct packed {
    logic             check;
    logic [KEY_W-1:0] key;
  } seen_req_t;

  typedef struct packed {
    logic hit;
    logic full;
  } seen_rsp_t;

endpackage

@@ hdl/dclp_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dclp_in_if
// Byte channel carrying the FIG 0/5 bytes with header and end marks.
// ----------------------------------------------------------------------------
interface dclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       fig_first;
  logic       fig_last;

  modport source (output valid, output data_byte, output fig_first, output fig_last,
                  input ready);
  modport sink   (input valid, input data_byte, input fig_first, input fig_last,
                  output ready);
endinterface

@@ hdl/dclp_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dclp_out_if
// Result channel carrying one parsed entry record per transaction.
// ----------------------------------------------------------------------------
interface dclp_out_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic        long_form;
  logic        fic_flag;
  logic [5:0]  short_id;
  logic [11:0] component_id;
  logic [7:0]  language_code;
  logic        rfa_invalid;
  logic        fig_done;
  logic        fig_complete;
  logic        seen_overflow;

  modport source (output valid, output entry_valid, output long_form, output fic_flag,
                  output short_id, output component_id, output language_code,
                  output rfa_invalid, output fig_done, output fig_complete,
                  output seen_overflow, input ready);
  modport sink   (input valid, input entry_valid, input long_form, input fic_flag,
                  input short_id, input component_id, input language_code,
                  input rfa_invalid, input fig_done, input fig_complete,
                  input seen_overflow, output ready);
endinterface

@@ hdl/dab_component_language_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dab_component_language_parser
// FIG 0/5 service component language parser with a seen-key set kept
// across FIGs.
// ----------------------------------------------------------------------------
// Takes one FIG byte per cycle while ready is high and gives its record, if
// any, through the output register. Each accepted byte is parsed, checked
// against the seen set and written to the output register, or to the skid
// slot behind it while a result waits, in the same cycle; the limit on clock
// rate is the parallel compare of a new key against all 64 stored keys. The
// skid slot lets one more byte in, so ready drops only when two results are
// held. The seen set starts empty after reset and needs no clearing time.
module dab_component_language_parser (
  input logic      clk,
  input logic      rst,
  dclp_in_if.sink  fig_bytes,
  dclp_out_if.source entries
);
  import dclp_pkg::*;

  logic      accept;
  logic      push;
  logic      can_accept;
  entry_t    rec;
  entry_t    out_rec;
  seen_req_t seen_req;
  seen_rsp_t seen_rsp;

  assign fig_bytes.ready = can_accept;
  assign accept          = fig_bytes.valid && can_accept;

  dclp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (fig_bytes.data_byte),
    .fig_first (fig_bytes.fig_first),
    .fig_last  (fig_bytes.fig_last),
    .seen_rsp  (seen_rsp),
    .seen_req  (seen_req),
    .push      (push),
    .rec       (rec)
  );

  dclp_seen_set u_seen (
    .clk (clk),
    .rst (rst),
    .req (seen_req),
    .rsp (seen_rsp)
  );

  dclp_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (rec),
    .can_accept (can_accept),
    .out_valid  (entries.valid),
    .out_data   (out_rec),
    .out_ready  (entries.ready)
  );

  assign entries.entry_valid   = out_rec.entry_valid;
  assign entries.long_form     = out_rec.long_form;
  assign entries.fic_flag      = out_rec.fic_flag;
  assign entries.short_id      = out_rec.short_id;
  assign entries.component_id  = out_rec.component_id;
  assign entries.language_code = out_rec.language_code;
  assign entries.rfa_invalid   = out_rec.rfa_invalid;
  assign entries.fig_done      = out_rec.fig_done;
  assign entries.fig_complete  = out_rec.fig_complete;
  assign entries.seen_overflow = out_rec.seen_overflow;

endmodule

@@ hdl/dclp_seen_set.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dclp_seen_set
// Key store with parallel compare. A hit empties the set; a miss appends the
// key unless the set is full.
// ----------------------------------------------------------------------------
module dclp_seen_set (
  input  logic                clk,
  input  logic                rst,
  input  dclp_pkg::seen_req_t req,
  output dclp_pkg::seen_rsp_t rsp
);
  import dclp_pkg::*;

  logic [KEY_W-1:0]      keys [SEEN_DEPTH];
  logic [SEEN_CNT_W-1:0] count;
  logic [SEEN_DEPTH-1:0] match;

  // only the filled part of the store takes part in the compare
  always_comb begin
    for (int k = 0; k < SEEN_DEPTH; k++) begin
      match[k] = (SEEN_CNT_W'(k) < count) && (keys[k] == req.key);
    end
    rsp.hit  = |match;
    rsp.full = (count == SEEN_CNT_W'(SEEN_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req.check) begin
      if (rsp.hit) begin
        count <= '0;
      end else if (!rsp.full) begin
        count <= count + SEEN_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.check && !rsp.hit && !rsp.full) begin
      keys[count[SEEN_IDX_W-1:0]] <= req.key;
    end
  end

endmodule

@@ hdl/dclp_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dclp_parser
// Entry framing over the FIG bytes: skips the header, assembles short and
// long form entries and builds the result record.
// ----------------------------------------------------------------------------
module dclp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                fig_first,
  input  logic                fig_last,
  input  dclp_pkg::seen_rsp_t seen_rsp,
  output dclp_pkg::seen_req_t seen_req,
  output logic                push,
  output dclp_pkg::entry_t    rec
);
  import dclp_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] first_byte, first_byte_next;
  logic [7:0] second_byte, second_byte_next;
  logic       repeat_seen, repeat_seen_next;
  logic       have;
  logic [11:0] scid;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FIRST;
      first_byte  <= '0;
      second_byte <= '0;
      repeat_seen <= 1'b0;
    end else begin
      phase       <= phase_next;
      first_byte  <= first_byte_next;
      second_byte <= second_byte_next;
      repeat_seen <= repeat_seen_next;
    end
  end

  assign scid = {first_byte[3:0] & SCID_MASK, second_byte};

  always_comb begin
    phase_next       = phase;
    first_byte_next  = first_byte;
    second_byte_next = second_byte;
    repeat_seen_next = repeat_seen;
    have             = 1'b0;
    seen_req         = '0;
    rec              = '0;

    if (accept) begin
      if (fig_first) begin
        phase_next       = PH_FIRST;
        repeat_seen_next = 1'b0;
      end else begin
        case (phase)
          PH_FIRST: begin
            first_byte_next = data_byte;
            phase_next      = PH_SECOND;
          end
          PH_SECOND: begin
            if (!first_byte[7]) begin
              have              = 1'b1;
              rec.fic_flag      = first_byte[6] & FLAG_MASK;
              rec.short_id      = 6'(first_byte & ID_MASK);
              rec.language_code = data_byte;
              seen_req.check    = 1'b1;
              seen_req.key      = {6'b0, rec.fic_flag, rec.short_id};
              phase_next        = PH_FIRST;
            end else begin
              second_byte_next = data_byte;
              phase_next       = PH_THIRD;
            end
          end
          PH_THIRD: begin
            have              = 1'b1;
            rec.long_form     = 1'b1;
            rec.rfa_invalid   = ((first_byte[6:4] & RFA_MASK) != 3'b0);
            rec.component_id  = scid;
            rec.language_code = data_byte;
            seen_req.check    = 1'b1;
            seen_req.key      = {1'b1, scid};
            phase_next        = PH_FIRST;
          end
          default: begin
            phase_next = PH_FIRST;
          end
        endcase
        if (have && seen_rsp.hit) begin
          repeat_seen_next = 1'b1;
        end
      end
      // a partial entry at the end of the FIG is dropped
      if (fig_last) begin
        phase_next = PH_FIRST;
      end
    end

    rec.entry_valid   = have;
    rec.seen_overflow = have && !seen_rsp.hit && seen_rsp.full;
    rec.fig_done      = fig_last;
    rec.fig_complete  = fig_last && repeat_seen_next;
    push              = accept && (have || fig_last);
  end

endmodule

@@ hdl/dclp_outbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dclp_outbuf
// Output register with one skid slot; upstream ready is registered.
// ----------------------------------------------------------------------------
module dclp_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dclp_pkg::entry_t push_data,
  output logic             can_accept,
  output logic             out_valid,
  output dclp_pkg::entry_t out_data,
  input  logic             out_ready
);
  import dclp_pkg::*;

  logic   skid_valid;
  entry_t skid_data;

  assign can_accept = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule
